[hw/rtl/csem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csem_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_TYPE_W = 2;
   localparam int ID_W       = 8;
   localparam int PRIO_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_TAKE    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_FLUSH   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUEUED    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RAISED    = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_WOKEN     = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_WOKEN_ERR = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_ORDER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_COUNT = 1'd1;

   // controller to datapath
   typedef struct packed {
      logic                capture;
      logic                load_result;
      logic [STATUS_W-1:0] status;
      logic                use_head;
      logic                last;
      logic                count_dec;
      logic                count_inc;
      logic                insert;
      logic                pop;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                  count_zero;
      logic [FILL_W-1:0]     fill;
      logic [REQ_TYPE_W-1:0] req_type;
      logic                  may_wait;
   } stat_type;

endpackage

`default_nettype wire

[hw/rtl/csem_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface csem_req_if;
   logic                              valid;
   logic                              ready;
   logic [csem_pkg::REQ_TYPE_W-1:0]   req_type;
   logic [csem_pkg::ID_W-1:0]         thread_id;
   logic [csem_pkg::PRIO_W-1:0]       thread_priority;
   logic                              may_wait;

   modport source (output valid, req_type, thread_id, thread_priority, may_wait,
                   input ready);
   modport sink (input valid, req_type, thread_id, thread_priority, may_wait,
                 output ready);
endinterface

interface csem_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [csem_pkg::STATUS_W-1:0]   status;
   logic [csem_pkg::ID_W-1:0]       woken_id;
   logic                            last;

   modport source (output valid, status, woken_id, last, input ready);
   modport sink (input valid, status, woken_id, last, output ready);
endinterface

`default_nettype wire

[hw/rtl/csem_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module csem_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire csem_pkg::stat_type stat,
   output csem_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EVAL  = 3'b010,
      S_FLUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;
   logic      full;
   logic      one_left;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign full      = (stat.fill == csem_pkg::FULL_FILL);
   assign one_left  = (stat.fill == csem_pkg::FILL_W'(1));
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            case (stat.req_type)
               csem_pkg::REQ_TAKE: begin
                  if (out_free) begin
                     cmd.load_result = 1'b1;
                     cmd.last        = 1'b1;
                     state_in        = S_IDLE;
                     if (!stat.count_zero) begin
                        cmd.count_dec = 1'b1;
                        cmd.status    = csem_pkg::STATUS_GRANTED;
                     end else if (!stat.may_wait) begin
                        cmd.status = csem_pkg::STATUS_TIMEOUT;
                     end else if (full) begin
                        cmd.status = csem_pkg::STATUS_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                        cmd.status = csem_pkg::STATUS_QUEUED;
                     end
                  end
               end
               csem_pkg::REQ_RELEASE: begin
                  if (out_free) begin
                     cmd.load_result = 1'b1;
                     cmd.last        = 1'b1;
                     state_in        = S_IDLE;
                     if (stat.fill != '0) begin
                        cmd.pop      = 1'b1;
                        cmd.use_head = 1'b1;
                        cmd.status   = csem_pkg::STATUS_WOKEN;
                     end else begin
                        cmd.count_inc = 1'b1;
                        cmd.status    = csem_pkg::STATUS_RAISED;
                     end
                  end
               end
               csem_pkg::REQ_FLUSH: begin
                  state_in = (stat.fill == '0) ? S_IDLE : S_FLUSH;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FLUSH: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               cmd.pop         = 1'b1;
               cmd.use_head    = 1'b1;
               cmd.status      = csem_pkg::STATUS_WOKEN_ERR;
               cmd.last        = one_left;
               if (one_left) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/csem_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module csem_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [csem_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [csem_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire logic [csem_pkg::REQ_TYPE_W-1:0]     req_type,
   input  wire logic [csem_pkg::ID_W-1:0]           thread_id,
   input  wire logic [csem_pkg::PRIO_W-1:0]         thread_priority,
   input  wire logic                                may_wait,
   input  wire csem_pkg::cmd_type                   cmd,
   output csem_pkg::stat_type                       stat,
   output logic [csem_pkg::STATUS_W-1:0]            rsp_status,
   output logic [csem_pkg::ID_W-1:0]                rsp_woken_id,
   output logic                                     rsp_last
);

   localparam int DEPTH = csem_pkg::QUEUE_DEPTH;

   // configuration and counters
   logic                              order_ff, order_in;
   logic [csem_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [csem_pkg::FILL_W-1:0]       fill_ff, fill_in;

   // held request and its per-entry compare vector
   logic [csem_pkg::REQ_TYPE_W-1:0]   req_type_ff;
   logic [csem_pkg::ID_W-1:0]         tid_ff;
   logic [csem_pkg::PRIO_W-1:0]       prio_ff;
   logic                              may_wait_ff;
   logic [DEPTH-1:0]                  hit_ff, hit_in;

   // wait queue, entry 0 is the head
   logic [csem_pkg::ID_W-1:0]         ids_ff   [DEPTH];
   logic [csem_pkg::ID_W-1:0]         ids_in   [DEPTH];
   logic [csem_pkg::PRIO_W-1:0]       prios_ff [DEPTH];
   logic [csem_pkg::PRIO_W-1:0]       prios_in [DEPTH];
   logic [DEPTH-1:0]                  at_or_after;

   logic [csem_pkg::STATUS_W-1:0]     status_ff;
   logic [csem_pkg::ID_W-1:0]         woken_ff;
   logic                              last_ff;

   function automatic logic [DEPTH-1:0] low_mask(input int upto);
      logic [DEPTH-1:0] m;
      m = '0;
      for (int j = 0; j < DEPTH; j++) begin
         m[j] = (j <= upto);
      end
      return m;
   endfunction

   assign stat.count_zero = (count_ff == '0);
   assign stat.fill       = fill_ff;
   assign stat.req_type   = req_type_ff;
   assign stat.may_wait   = may_wait_ff;

   assign rsp_status   = status_ff;
   assign rsp_woken_id = woken_ff;
   assign rsp_last     = last_ff;

   // entries that a more urgent newcomer goes in front of
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit_in[i] = order_ff && (csem_pkg::FILL_W'(i) < fill_ff)
                     && (thread_priority < prios_ff[i]);
      end
   end

   // slot i lies at or after the insert point
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         at_or_after[i] = (|(hit_ff & low_mask(i))) || (csem_pkg::FILL_W'(i) >= fill_ff);
      end
   end

   always_comb begin
      ids_in   = ids_ff;
      prios_in = prios_ff;
      if (cmd.insert) begin
         if (at_or_after[0]) begin
            ids_in[0]   = tid_ff;
            prios_in[0] = prio_ff;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (at_or_after[i] && !at_or_after[i-1]) begin
               ids_in[i]   = tid_ff;
               prios_in[i] = prio_ff;
            end else if (at_or_after[i-1]) begin
               ids_in[i]   = ids_ff[i-1];
               prios_in[i] = prios_ff[i-1];
            end
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            ids_in[i]   = ids_ff[i+1];
            prios_in[i] = prios_ff[i+1];
         end
      end
   end

   always_comb begin
      order_in = order_ff;
      count_in = count_ff;
      if (csr_write_en && (csr_index == csem_pkg::CSR_WAIT_ORDER)) begin
         order_in = csr_write_data[0];
      end
      if (csr_write_en && (csr_index == csem_pkg::CSR_INIT_COUNT)) begin
         count_in = csr_write_data[csem_pkg::COUNT_W-1:0];
      end else if (cmd.count_dec) begin
         count_in = count_ff - csem_pkg::COUNT_W'(1);
      end else if (cmd.count_inc && (count_ff != '1)) begin
         count_in = count_ff + csem_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.insert) begin
         fill_in = fill_ff + csem_pkg::FILL_W'(1);
      end else if (cmd.pop) begin
         fill_in = fill_ff - csem_pkg::FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         order_ff <= order_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      ids_ff   <= ids_in;
      prios_ff <= prios_in;
      if (cmd.capture) begin
         req_type_ff <= req_type;
         tid_ff      <= thread_id;
         prio_ff     <= thread_priority;
         may_wait_ff <= may_wait;
         hit_ff      <= hit_in;
      end
      if (cmd.load_result) begin
         status_ff <= cmd.status;
         woken_ff  <= cmd.use_head ? ids_ff[0] : '0;
         last_ff   <= cmd.last;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/counting_semaphore_wait_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel     dir  handshake        word
// req_chan    in   valid / ready    req_type, thread_id, thread_priority, may_wait
// rsp_chan    out  valid / ready    status, woken_id, last
// csr_*       in   write enable     csr_index, csr_write_data (no read-back)
//
// take and release: the request is latched with its per-entry priority
//   compares, then the evaluate step updates queue/count and loads the result
// flush: after latch and evaluate, the flush drain pops the queue head each cycle unless rsp_chan stalls
// a new request is taken while a finished word still sits in the output register
// a stalled rsp_chan holds the evaluate or flush step until the word is taken
// reset clears the count, fill level and wait order; queue entries are not cleared

module counting_semaphore_wait_queue_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [csem_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [csem_pkg::CSR_DATA_W-1:0] csr_write_data,
   csem_req_if.sink                             req_chan,
   csem_rsp_if.source                           rsp_chan
);

   // command and status between the sequencer and the queue datapath
   csem_pkg::cmd_type  cmd;
   csem_pkg::stat_type stat;

   logic req_ready;
   logic rsp_valid;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // sequencer: idle, evaluate, flush drain
   csem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // count, ordered wait queue and output word register
   csem_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_type        (req_chan.req_type),
      .thread_id       (req_chan.thread_id),
      .thread_priority (req_chan.thread_priority),
      .may_wait        (req_chan.may_wait),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_chan.status),
      .rsp_woken_id    (rsp_chan.woken_id),
      .rsp_last        (rsp_chan.last)
   );

`ifndef ASSERT_OFF
   // never insert into a full queue
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (stat.fill != csem_pkg::FULL_FILL))
      else $error("insert into full wait queue");

   // fill level stays within the queue depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stat.fill <= csem_pkg::FULL_FILL)
      else $error("wait queue fill beyond depth");

   // the final flush word leaves the queue empty
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && cmd.last && (cmd.status == csem_pkg::STATUS_WOKEN_ERR))
      |=> (stat.fill == '0))
      else $error("queue not empty after final flush word");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while another is being evaluated");
`endif

endmodule

`default_nettype wire
